[rtl/mag_hdg_pkg.sv]
// ============================================================================
// mag_hdg_pkg: shared types and constants for the magnetometer heading block
// Item control flags, register indexes, arctangent table and width helpers.
// ============================================================================
package mag_hdg_pkg;

    // Control bits that travel with every item through the pipeline
    typedef struct packed {
        logic valid;
        logic usable;
        logic last;
        logic zero;
    } mag_hdg_ctl_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_LOW          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_HIGH         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_LOW          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_HIGH         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEADING_OFFSET = 3'd4;

    localparam logic signed [31:0] X_LOW_RESET  = -32'sd3128;
    localparam logic signed [31:0] X_HIGH_RESET = -32'sd937;
    localparam logic signed [31:0] Y_LOW_RESET  = -32'sd759;
    localparam logic signed [31:0] Y_HIGH_RESET = 32'sd848;

    // Angle accumulator: 2^32 per turn
    localparam int ACC_BITS = 32;
    localparam logic [ACC_BITS-1:0] ACC_HALF_TURN = 32'h8000_0000;

    // Normalize until the larger magnitude reaches 2^NORM_BIT
    localparam int NORM_BIT = 48;
    localparam int NSHIFT   = 6;

    localparam int TABLE_LEN = 24;
    localparam logic [ACC_BITS-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Datapath width for the vector after normalization and CORDIC growth
    function automatic int work_bits(input int field_bits);
        int m;
        m = 2 * field_bits + 1;
        if (m < NORM_BIT + 1)
        begin
            m = NORM_BIT + 1;
        end
        return m + 3;
    endfunction

endpackage

[rtl/mag_hdg_prep.sv]
// ============================================================================
// mag_hdg_prep: calibration centering and cross-multiplication
// Stage A forms centered values and spans; stage B forms the scaled vector.
// ============================================================================
module mag_hdg_prep #(
    parameter int FIELD_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 in_valid,
    input  logic signed [FIELD_BITS-1:0]         mag_x,
    input  logic signed [FIELD_BITS-1:0]         mag_y,
    input  logic                                 reading_unknown,
    input  logic                                 last_in_batch,
    input  logic signed [FIELD_BITS-1:0]         x_low,
    input  logic signed [FIELD_BITS-1:0]         x_high,
    input  logic signed [FIELD_BITS-1:0]         y_low,
    input  logic signed [FIELD_BITS-1:0]         y_high,
    output logic signed [2*FIELD_BITS+2:0]       prod_x,
    output logic signed [2*FIELD_BITS+2:0]       prod_y,
    output mag_hdg_pkg::mag_hdg_ctl_t            ctl_out
);

    localparam int AW = FIELD_BITS + 2;
    localparam int DW = FIELD_BITS + 1;
    localparam int PW = AW + DW;

    logic signed [AW-1:0] ax_next, ay_next, ax_reg, ay_reg;
    logic signed [DW-1:0] dx_next, dy_next, dx_reg, dy_reg;
    mag_hdg_pkg::mag_hdg_ctl_t ctl_a_next, ctl_a_reg, ctl_b_reg;
    logic signed [PW-1:0] prod_x_reg, prod_y_reg;

    always_comb
    begin
        ax_next = AW'(mag_x) + AW'(mag_x) - AW'(x_low) - AW'(x_high);
        ay_next = AW'(mag_y) + AW'(mag_y) - AW'(y_low) - AW'(y_high);
        dx_next = DW'(x_high) - DW'(x_low);
        dy_next = DW'(y_high) - DW'(y_low);
        ctl_a_next.valid  = in_valid;
        ctl_a_next.usable = !reading_unknown && (dx_next > 0) && (dy_next > 0);
        ctl_a_next.last   = last_in_batch;
        ctl_a_next.zero   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (adv)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            prod_x_reg <= PW'(ax_reg) * PW'(dy_reg);
            prod_y_reg <= PW'(ay_reg) * PW'(dx_reg);
        end
    end

    assign prod_x  = prod_x_reg;
    assign prod_y  = prod_y_reg;
    assign ctl_out = ctl_b_reg;

endmodule

[rtl/mag_hdg_norm.sv]
// ============================================================================
// mag_hdg_norm: half-plane fold and pipelined normalization
// Fold the vector into the right half plane, then shift left in binary steps
// until the larger magnitude reaches the normalization bit.
// ============================================================================
module mag_hdg_norm #(
    parameter int FIELD_BITS = 16
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   adv,
    input  logic signed [2*FIELD_BITS+2:0]                         prod_x,
    input  logic signed [2*FIELD_BITS+2:0]                         prod_y,
    input  mag_hdg_pkg::mag_hdg_ctl_t                              ctl_in,
    output logic signed [mag_hdg_pkg::work_bits(FIELD_BITS)-1:0]   x_out,
    output logic signed [mag_hdg_pkg::work_bits(FIELD_BITS)-1:0]   y_out,
    output logic [mag_hdg_pkg::ACC_BITS-1:0]                       acc_out,
    output mag_hdg_pkg::mag_hdg_ctl_t                              ctl_out
);

    localparam int PW = 2 * FIELD_BITS + 3;
    localparam int WB = mag_hdg_pkg::work_bits(FIELD_BITS);
    localparam int NS = mag_hdg_pkg::NSHIFT;

    logic signed [WB-1:0] xw, yw, xn_next, yn_next, ya;
    logic [WB-1:0] om_next;
    logic neg;
    logic [mag_hdg_pkg::ACC_BITS-1:0] acc_next;
    mag_hdg_pkg::mag_hdg_ctl_t ctl_next;

    logic signed [WB-1:0] sx [NS+1];
    logic signed [WB-1:0] sy [NS+1];
    logic [WB-1:0] som [NS+1];
    logic [mag_hdg_pkg::ACC_BITS-1:0] sacc [NS+1];
    mag_hdg_pkg::mag_hdg_ctl_t sctl [NS+1];

    logic signed [WB-1:0] sx_reg [NS+1];
    logic signed [WB-1:0] sy_reg [NS+1];
    logic [WB-1:0] som_reg [NS+1];
    logic [mag_hdg_pkg::ACC_BITS-1:0] sacc_reg [NS+1];
    mag_hdg_pkg::mag_hdg_ctl_t sctl_reg [NS+1];

    always_comb
    begin
        xw       = WB'(prod_x);
        yw       = WB'(prod_y);
        neg      = prod_x[PW-1];
        xn_next  = neg ? -xw : xw;
        yn_next  = neg ? -yw : yw;
        ya       = yw[WB-1] ? -yw : yw;
        om_next  = $unsigned(xn_next) | $unsigned(ya);
        acc_next = neg ? mag_hdg_pkg::ACC_HALF_TURN : '0;
        ctl_next      = ctl_in;
        ctl_next.zero = (prod_x == '0) && (prod_y == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sctl_reg[0] <= '0;
        end
        else if (adv)
        begin
            sctl_reg[0] <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg[0]   <= xn_next;
            sy_reg[0]   <= yn_next;
            som_reg[0]  <= om_next;
            sacc_reg[0] <= acc_next;
        end
    end

    assign sx[0]   = sx_reg[0];
    assign sy[0]   = sy_reg[0];
    assign som[0]  = som_reg[0];
    assign sacc[0] = sacc_reg[0];
    assign sctl[0] = sctl_reg[0];

    for (genvar g = 0; g < NS; g++)
    begin : g_shift
        localparam int K = 1 << (NS - 1 - g);
        logic lift;

        // shift only while the leading bit stays at or below the target
        assign lift = (som[g] >> (mag_hdg_pkg::NORM_BIT + 1 - K)) == '0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sctl_reg[g+1] <= '0;
            end
            else if (adv)
            begin
                sctl_reg[g+1] <= sctl[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg[g+1]   <= lift ? (sx[g] <<< K) : sx[g];
                sy_reg[g+1]   <= lift ? (sy[g] <<< K) : sy[g];
                som_reg[g+1]  <= lift ? (som[g] << K) : som[g];
                sacc_reg[g+1] <= sacc[g];
            end
        end

        assign sx[g+1]   = sx_reg[g+1];
        assign sy[g+1]   = sy_reg[g+1];
        assign som[g+1]  = som_reg[g+1];
        assign sacc[g+1] = sacc_reg[g+1];
        assign sctl[g+1] = sctl_reg[g+1];
    end

    assign x_out   = sx[NS];
    assign y_out   = sy[NS];
    assign acc_out = sacc[NS];
    assign ctl_out = sctl[NS];

    a_norm_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (sctl[NS].valid && sctl[NS].usable && !sctl[NS].zero)
        |-> (som[NS][WB-1:mag_hdg_pkg::NORM_BIT] != '0))
        else $error("normalized vector below target magnitude");

    a_fold_right: assert property (@(posedge clk) disable iff (!rst_n)
        (sctl[NS].valid && sctl[NS].usable) |-> !sx[NS][WB-1])
        else $error("folded x component is negative");

endmodule

[rtl/mag_hdg_cordic.sv]
// ============================================================================
// mag_hdg_cordic: pipelined vectoring CORDIC
// One register stage per step; each step rotates toward the x axis and
// accumulates the step angle in units of 2^32 per turn.
// ============================================================================
module mag_hdg_cordic #(
    parameter int WORK_BITS    = 52,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic signed [WORK_BITS-1:0]         x_in,
    input  logic signed [WORK_BITS-1:0]         y_in,
    input  logic [mag_hdg_pkg::ACC_BITS-1:0]    acc_in,
    input  mag_hdg_pkg::mag_hdg_ctl_t           ctl_in,
    output logic [mag_hdg_pkg::ACC_BITS-1:0]    acc_out,
    output mag_hdg_pkg::mag_hdg_ctl_t           ctl_out
);

    logic signed [WORK_BITS-1:0] cx [CORDIC_STEPS+1];
    logic signed [WORK_BITS-1:0] cy [CORDIC_STEPS+1];
    logic [mag_hdg_pkg::ACC_BITS-1:0] cacc [CORDIC_STEPS+1];
    mag_hdg_pkg::mag_hdg_ctl_t cctl [CORDIC_STEPS+1];

    logic signed [WORK_BITS-1:0] cx_reg [CORDIC_STEPS];
    logic signed [WORK_BITS-1:0] cy_reg [CORDIC_STEPS];
    logic [mag_hdg_pkg::ACC_BITS-1:0] cacc_reg [CORDIC_STEPS];
    mag_hdg_pkg::mag_hdg_ctl_t cctl_reg [CORDIC_STEPS];

    assign cx[0]   = x_in;
    assign cy[0]   = y_in;
    assign cacc[0] = acc_in;
    assign cctl[0] = ctl_in;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [WORK_BITS-1:0] xs, ys;
        logic down;

        assign xs   = cx[i] >>> i;
        assign ys   = cy[i] >>> i;
        assign down = cy[i][WORK_BITS-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cctl_reg[i] <= '0;
            end
            else if (adv)
            begin
                cctl_reg[i] <= cctl[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (down)
                begin
                    cx_reg[i]   <= cx[i] - ys;
                    cy_reg[i]   <= cy[i] + xs;
                    cacc_reg[i] <= cacc[i] - mag_hdg_pkg::ATAN_TURNS[i];
                end
                else
                begin
                    cx_reg[i]   <= cx[i] + ys;
                    cy_reg[i]   <= cy[i] - xs;
                    cacc_reg[i] <= cacc[i] + mag_hdg_pkg::ATAN_TURNS[i];
                end
            end
        end

        assign cx[i+1]   = cx_reg[i];
        assign cy[i+1]   = cy_reg[i];
        assign cacc[i+1] = cacc_reg[i];
        assign cctl[i+1] = cctl_reg[i];
    end

    assign acc_out = cacc[CORDIC_STEPS];
    assign ctl_out = cctl[CORDIC_STEPS];

endmodule

[rtl/magnetometer_heading.sv]
// ============================================================================
// magnetometer_heading: calibrated compass heading from magnetometer samples
// Centers and scales x/y with calibration limits, finds atan2 by pipelined
// CORDIC and adds a heading offset as a binary angle.
// ============================================================================
//
//   port group    dir   handshake           payload
//   in            in    in_valid/in_ready   mag_x mag_y mag_z reading_unknown
//                                           last_in_batch
//   out           out   out_valid/out_ready heading heading_valid batch_end
//   cfg           in    cfg_we              cfg_index cfg_data
//
// One item enters every cycle while the skid entry is empty; the pipeline has
// two calibration/multiply stages, seven fold/normalize stages, one stage per
// CORDIC step, and the rounding/output register.
// Reset clears all valid bits and loads the calibration defaults.
// An output register plus one skid entry absorb a stall; the pipeline
// holds in place while the skid entry is occupied.
// mag_z is carried only for interface completeness.
//
module magnetometer_heading #(
    parameter int FIELD_BITS   = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [FIELD_BITS-1:0]                mag_x,
    input  logic signed [FIELD_BITS-1:0]                mag_y,
    input  logic signed [FIELD_BITS-1:0]                mag_z,
    input  logic                                        reading_unknown,
    input  logic                                        last_in_batch,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic signed [ANGLE_BITS-1:0]                heading,
    output logic                                        heading_valid,
    output logic                                        batch_end,
    input  logic                                        cfg_we,
    input  logic [mag_hdg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [((FIELD_BITS > ANGLE_BITS) ? FIELD_BITS : ANGLE_BITS)-1:0] cfg_data
);

    localparam int PW = 2 * FIELD_BITS + 3;
    localparam int WB = mag_hdg_pkg::work_bits(FIELD_BITS);
    localparam int AB = mag_hdg_pkg::ACC_BITS;

    logic signed [FIELD_BITS-1:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic [ANGLE_BITS-1:0] offset_reg;

    logic adv;
    logic signed [PW-1:0] prod_x, prod_y;
    mag_hdg_pkg::mag_hdg_ctl_t prep_ctl, norm_ctl, fin_ctl;
    logic signed [WB-1:0] norm_x, norm_y;
    logic [AB-1:0] norm_acc, fin_acc;

    logic [AB:0] round_sum;
    logic [ANGLE_BITS-1:0] fin_heading, turn_angle;

    logic out_valid_reg, out_valid_next, skid_valid_reg, skid_valid_next;
    logic [ANGLE_BITS-1:0] out_heading_reg, out_heading_next;
    logic [ANGLE_BITS-1:0] skid_heading_reg, skid_heading_next;
    logic out_hv_reg, out_hv_next, skid_hv_reg, skid_hv_next;
    logic out_last_reg, out_last_next, skid_last_reg, skid_last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg  <= mag_hdg_pkg::X_LOW_RESET[FIELD_BITS-1:0];
            x_high_reg <= mag_hdg_pkg::X_HIGH_RESET[FIELD_BITS-1:0];
            y_low_reg  <= mag_hdg_pkg::Y_LOW_RESET[FIELD_BITS-1:0];
            y_high_reg <= mag_hdg_pkg::Y_HIGH_RESET[FIELD_BITS-1:0];
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mag_hdg_pkg::REG_X_LOW:          x_low_reg  <= cfg_data[FIELD_BITS-1:0];
                mag_hdg_pkg::REG_X_HIGH:         x_high_reg <= cfg_data[FIELD_BITS-1:0];
                mag_hdg_pkg::REG_Y_LOW:          y_low_reg  <= cfg_data[FIELD_BITS-1:0];
                mag_hdg_pkg::REG_Y_HIGH:         y_high_reg <= cfg_data[FIELD_BITS-1:0];
                mag_hdg_pkg::REG_HEADING_OFFSET: offset_reg <= cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    mag_hdg_prep #(
        .FIELD_BITS (FIELD_BITS)
    ) u_prep (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (in_valid),
        .mag_x           (mag_x),
        .mag_y           (mag_y),
        .reading_unknown (reading_unknown),
        .last_in_batch   (last_in_batch),
        .x_low           (x_low_reg),
        .x_high          (x_high_reg),
        .y_low           (y_low_reg),
        .y_high          (y_high_reg),
        .prod_x          (prod_x),
        .prod_y          (prod_y),
        .ctl_out         (prep_ctl)
    );

    mag_hdg_norm #(
        .FIELD_BITS (FIELD_BITS)
    ) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .prod_x  (prod_x),
        .prod_y  (prod_y),
        .ctl_in  (prep_ctl),
        .x_out   (norm_x),
        .y_out   (norm_y),
        .acc_out (norm_acc),
        .ctl_out (norm_ctl)
    );

    mag_hdg_cordic #(
        .WORK_BITS    (WB),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .x_in    (norm_x),
        .y_in    (norm_y),
        .acc_in  (norm_acc),
        .ctl_in  (norm_ctl),
        .acc_out (fin_acc),
        .ctl_out (fin_ctl)
    );

    // round to nearest, add offset, force zero for unusable items
    always_comb
    begin
        round_sum   = {1'b0, fin_acc} + ((AB + 1)'(1) << (AB - 1 - ANGLE_BITS));
        turn_angle  = fin_ctl.zero ? '0 : round_sum[AB-1 -: ANGLE_BITS];
        fin_heading = fin_ctl.usable ? (turn_angle + offset_reg) : '0;
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_heading_next  = out_heading_reg;
        out_hv_next       = out_hv_reg;
        out_last_next     = out_last_reg;
        skid_valid_next   = skid_valid_reg;
        skid_heading_next = skid_heading_reg;
        skid_hv_next      = skid_hv_reg;
        skid_last_next    = skid_last_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_heading_next = skid_heading_reg;
                out_hv_next      = skid_hv_reg;
                out_last_next    = skid_last_reg;
                skid_valid_next  = 1'b0;
            end
            else if (fin_ctl.valid)
            begin
                out_valid_next   = 1'b1;
                out_heading_next = fin_heading;
                out_hv_next      = fin_ctl.usable;
                out_last_next    = fin_ctl.last;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (fin_ctl.valid && !skid_valid_reg)
        begin
            skid_valid_next   = 1'b1;
            skid_heading_next = fin_heading;
            skid_hv_next      = fin_ctl.usable;
            skid_last_next    = fin_ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_heading_reg  <= out_heading_next;
        out_hv_reg       <= out_hv_next;
        out_last_reg     <= out_last_next;
        skid_heading_reg <= skid_heading_next;
        skid_hv_reg      <= skid_hv_next;
        skid_last_reg    <= skid_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign heading       = out_heading_reg;
    assign heading_valid = out_hv_reg;
    assign batch_end     = out_last_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled without an output stall");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hv_reg) |-> (out_heading_reg == '0))
        else $error("unusable item carries a nonzero heading");

endmodule

[tb/tb_magnetometer_heading.sv]
// ============================================================================
// tb_magnetometer_heading: self-checking bench for the compass heading block
// Drives magnetometer samples through the valid/ready input with random gaps,
// stalls the result side at random and checks every heading, valid flag and
// batch mark against a bit-exact CORDIC prediction. Calibration is changed
// between phases while the block is idle, including extreme and invalid
// limits.
// ============================================================================
module tb_magnetometer_heading;

    localparam int FW         = 16;
    localparam int AW         = 16;
    localparam int CW         = (FW > AW) ? FW : AW;
    localparam int IW         = mag_hdg_pkg::CFG_INDEX_BITS;
    localparam int STEPS      = 16;
    localparam int LATENCY    = STEPS + 10;
    localparam int ITEMS      = 1350;
    localparam int CALM_FROM  = 500;
    localparam int CALM_TO    = 800;
    localparam int QUIET_MAX  = 4000;
    localparam int FMAX       = 32767;
    localparam int FMIN       = -32768;
    localparam logic [IW-1:0] REG_SPARE_FIRST =
        IW'(mag_hdg_pkg::REG_HEADING_OFFSET + 1);

    typedef struct {
        logic signed [AW-1:0] heading;
        logic                 heading_valid;
        logic                 batch_end;
    } bearing_t;

    class heading_ledger;
        logic signed [FW-1:0] x_lo  = -16'sd3128;
        logic signed [FW-1:0] x_hi  = -16'sd937;
        logic signed [FW-1:0] y_lo  = -16'sd759;
        logic signed [FW-1:0] y_hi  = 16'sd848;
        logic signed [AW-1:0] offset = '0;
        bearing_t due_headings[$];
        int errors = 0;

        // arctangent of 2^-i in units of 2^32 per turn
        logic [31:0] arc_step[24] = '{
            32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
            32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
            32'd166886,    32'd83443,     32'd41722,     32'd20861,
            32'd10430,     32'd5215,      32'd2608,      32'd1304,
            32'd652,       32'd326,       32'd163,       32'd81
        };

        function void set_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
            case (idx)
                mag_hdg_pkg::REG_X_LOW:          x_lo = val[FW-1:0];
                mag_hdg_pkg::REG_X_HIGH:         x_hi = val[FW-1:0];
                mag_hdg_pkg::REG_Y_LOW:          y_lo = val[FW-1:0];
                mag_hdg_pkg::REG_Y_HIGH:         y_hi = val[FW-1:0];
                mag_hdg_pkg::REG_HEADING_OFFSET: offset = val[AW-1:0];
                default:            ;
            endcase
        endfunction

        function logic [31:0] compass_angle(longint vx, longint vy);
            logic [31:0] acc;
            longint      xs;
            longint      ys;
            longint      lim;
            int          i;
            acc = '0;
            lim = longint'(1) << 48;
            if (vx == 0 && vy == 0)
                return '0;
            if (vx < 0)
            begin
                vx  = -vx;
                vy  = -vy;
                acc = 32'h8000_0000;
            end
            while ((vx < 0 ? -vx : vx) < lim && (vy < 0 ? -vy : vy) < lim)
            begin
                vx = vx * 2;
                vy = vy * 2;
            end
            for (i = 0; i < STEPS && i < 24; i++)
            begin
                xs = vx >>> i;
                ys = vy >>> i;
                if (vy < 0)
                begin
                    vx  = vx - ys;
                    vy  = vy + xs;
                    acc = acc - arc_step[i];
                end
                else
                begin
                    vx  = vx + ys;
                    vy  = vy - xs;
                    acc = acc + arc_step[i];
                end
            end
            return acc;
        endfunction

        function void note_sample(logic signed [FW-1:0] mx, logic signed [FW-1:0] my,
                                  logic unk, logic lst);
            bearing_t    want;
            longint      xl;
            longint      xh;
            longint      yl;
            longint      yh;
            longint      px;
            longint      py;
            longint      dx;
            longint      dy;
            logic [32:0] rounded;
            xl = x_lo;
            xh = x_hi;
            yl = y_lo;
            yh = y_hi;
            px = mx;
            py = my;
            dx = xh - xl;
            dy = yh - yl;
            want.heading       = '0;
            want.heading_valid = 1'b0;
            want.batch_end     = lst;
            if (!unk && dx > 0 && dy > 0)
            begin
                rounded = ({1'b0, compass_angle((2 * px - xl - xh) * dy,
                                                (2 * py - yl - yh) * dx)}
                           + (33'd1 << (31 - AW))) >> (32 - AW);
                want.heading       = rounded[AW-1:0] + offset;
                want.heading_valid = 1'b1;
            end
            due_headings.push_back(want);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", what);
        endfunction

        function void check_result(logic signed [AW-1:0] h, logic hv, logic be);
            bearing_t want;
            if (due_headings.size() == 0)
            begin
                flag($sformatf("unexpected result heading %0d valid %0b end %0b", h, hv, be));
                return;
            end
            want = due_headings.pop_front();
            if (h !== want.heading || hv !== want.heading_valid || be !== want.batch_end)
                flag($sformatf("expected heading %0d valid %0b end %0b, got %0d %0b %0b",
                               want.heading, want.heading_valid, want.batch_end, h, hv, be));
        endfunction

        function int pending();
            return due_headings.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [FW-1:0]        mag_x;
    logic signed [FW-1:0]        mag_y;
    logic signed [FW-1:0]        mag_z;
    logic                        reading_unknown;
    logic                        last_in_batch;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [AW-1:0]        heading;
    logic                        heading_valid;
    logic                        batch_end;
    logic                        cfg_we;
    logic [IW-1:0]               cfg_index;
    logic [CW-1:0]               cfg_data;

    heading_ledger board;
    int            sent;
    int            quiet = 0;
    bit            calm;

    magnetometer_heading #(
        .FIELD_BITS   (FW),
        .ANGLE_BITS   (AW),
        .CORDIC_STEPS (STEPS)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mag_x           (mag_x),
        .mag_y           (mag_y),
        .mag_z           (mag_z),
        .reading_unknown (reading_unknown),
        .last_in_batch   (last_in_batch),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .heading         (heading),
        .heading_valid   (heading_valid),
        .batch_end       (batch_end),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 30);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(heading, heading_valid, batch_end);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= QUIET_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic int any_field();
        logic signed [FW-1:0] v;
        v = FW'($urandom);
        return int'(v);
    endfunction

    task automatic send_sample(input int x, input int y, input int z,
                               input logic unk, input logic lst);
        calm = (sent >= CALM_FROM && sent < CALM_TO);
        while (!calm && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        mag_x           <= x[FW-1:0];
        mag_y           <= y[FW-1:0];
        mag_z           <= z[FW-1:0];
        reading_unknown <= unk;
        last_in_batch   <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_sample(mag_x, mag_y, reading_unknown, last_in_batch);
        sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CW-1:0];
        @(posedge clk);
        board.set_reg(idx, val[CW-1:0]);
    endtask

    task automatic calibrate(input int xl, input int xh, input int yl, input int yh,
                             input int off, input bit spare);
        settle();
        write_reg(mag_hdg_pkg::REG_X_LOW, xl);
        write_reg(mag_hdg_pkg::REG_X_HIGH, xh);
        write_reg(mag_hdg_pkg::REG_Y_LOW, yl);
        write_reg(mag_hdg_pkg::REG_Y_HIGH, yh);
        write_reg(mag_hdg_pkg::REG_HEADING_OFFSET, off);
        if (spare)
            write_reg(IW'($urandom_range((1 << IW) - 1, REG_SPARE_FIRST)),
                      int'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int a;
        int b;
        int c;
        int d;
        int t;
        int xl;
        int xh;
        int yl;
        int yh;
        int pick;
        int n;
        int mx;
        int my;
        board           = new();
        sent            = 0;
        calm            = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mag_x           = '0;
        mag_y           = '0;
        mag_z           = '0;
        reading_unknown = 1'b0;
        last_in_batch   = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = mag_hdg_pkg::REG_X_LOW;
        cfg_data        = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration: field extremes, unknown mark, near-center sample
        send_sample(FMAX, FMAX, FMAX, 1'b0, 1'b0);
        send_sample(FMIN, FMIN, FMIN, 1'b0, 1'b1);
        send_sample(FMAX, FMIN, 0, 1'b0, 1'b0);
        send_sample(FMIN, FMAX, 0, 1'b0, 1'b0);
        send_sample(0, 0, 0, 1'b1, 1'b1);
        send_sample(-2032, 44, 0, 1'b0, 1'b0);

        // symmetric limits: zero vector, axes, negative x with and without y
        calibrate(-1000, 1000, -500, 500, 16384, 1'b0);
        send_sample(0, 0, 0, 1'b0, 1'b0);
        send_sample(1000, 0, 0, 1'b0, 1'b0);
        send_sample(0, 500, 0, 1'b0, 1'b0);
        send_sample(-1000, 0, 0, 1'b0, 1'b0);
        send_sample(-1000, -1, 0, 1'b0, 1'b0);
        send_sample(0, -500, 0, 1'b0, 1'b1);
        send_sample(0, 0, FMIN, 1'b1, 1'b0);

        // widest limits, largest offset
        calibrate(FMIN, FMAX, FMIN, FMAX, FMAX, 1'b0);
        send_sample(FMAX, FMAX, 0, 1'b0, 1'b0);
        send_sample(FMIN, FMIN, 0, 1'b0, 1'b0);
        send_sample(FMAX, FMIN, 0, 1'b0, 1'b1);

        // empty x span
        calibrate(100, 100, -500, 500, 0, 1'b0);
        send_sample(5, 5, 0, 1'b0, 1'b0);
        send_sample(FMIN, FMAX, 0, 1'b0, 1'b1);

        // inverted y span
        calibrate(-100, 100, 200, -200, FMIN, 1'b0);
        send_sample(3, 4, 0, 1'b0, 1'b0);

        // spare register index must leave the limits alone
        calibrate(-100, 100, -200, 200, FMIN, 1'b1);
        send_sample(50, 60, 0, 1'b0, 1'b0);
        send_sample(-50, -60, 0, 1'b0, 1'b0);
        send_sample(FMAX, 0, 0, 1'b0, 1'b1);

        while (sent < ITEMS)
        begin
            pick = $urandom_range(99);
            a = any_field();
            b = any_field();
            c = any_field();
            d = any_field();
            xl = (a < b) ? a : b;
            xh = (a < b) ? b : a;
            yl = (c < d) ? c : d;
            yh = (c < d) ? d : c;
            if (pick < 6)
            begin
                t  = xl;
                xl = xh;
                xh = t;
            end
            else if (pick < 12)
            begin
                t  = yl;
                yl = yh;
                yh = t;
            end
            else if (pick < 18)
            begin
                xl = FMIN + $urandom_range(50);
                xh = FMAX - $urandom_range(50);
                yl = FMIN + $urandom_range(50);
                yh = FMAX - $urandom_range(50);
            end
            else if (pick < 30)
            begin
                xl = FMIN + $urandom_range(65535 - 64);
                xh = xl + $urandom_range(64, 1);
                yl = FMIN + $urandom_range(65535 - 64);
                yh = yl + $urandom_range(64, 1);
            end
            calibrate(xl, xh, yl, yh, any_field(), $urandom_range(99) < 20);
            n = $urandom_range(80, 10);
            repeat (n)
            begin
                if ($urandom_range(99) < 60 && xl < xh && yl < yh)
                begin
                    mx = xl + $urandom_range(xh - xl);
                    my = yl + $urandom_range(yh - yl);
                end
                else
                begin
                    mx = any_field();
                    my = any_field();
                end
                send_sample(mx, my, any_field(), $urandom_range(99) < 8,
                            $urandom_range(9) == 0);
            end
        end

        settle();
        repeat (LATENCY + 8) @(posedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d headings never arrived", board.pending()));
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
